@@ rtl/core/mrl_pkg.sv @@
package mrl_pkg;

    localparam int COORD_BITS = 10;
    // zone-0 coordinates and deltas need one more bit (negated minimum)
    localparam int ZW = COORD_BITS + 1;
    // decision term and increments
    localparam int DW = COORD_BITS + 3;

    localparam int IN_FIELD_W  = 4 * COORD_BITS + 2;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * COORD_BITS + 2;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ZONE0 = 3'd0,
        ZONE1 = 3'd1,
        ZONE2 = 3'd2,
        ZONE3 = 3'd3,
        ZONE4 = 3'd4,
        ZONE5 = 3'd5,
        ZONE6 = 3'd6,
        ZONE7 = 3'd7
    } zone_t;

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
    } point_t;

    // one queued command; line setup fields are only meaningful for OP_BEGIN
    typedef struct packed {
        op_t                  op;
        zone_t                zone;
        logic signed [ZW-1:0] start_x;
        logic signed [ZW-1:0] start_y;
        logic signed [ZW-1:0] stop_x;
        logic signed [DW-1:0] decision;
        logic signed [DW-1:0] east_inc;
        logic signed [DW-1:0] diag_inc;
        logic [1:0]           color;
    } entry_t;

    function automatic zone_t pick_zone(input logic signed [ZW-1:0] dx,
                                        input logic signed [ZW-1:0] dy);
        logic signed [ZW-1:0] ndx;
        logic signed [ZW-1:0] ndy;
        zone_t                z;
        ndx = -dx;
        ndy = -dy;
        priority if (!dx[ZW-1] && !dy[ZW-1]) begin
            z = (dx >= dy) ? ZONE0 : ZONE1;
        end else if (dx[ZW-1] && !dy[ZW-1]) begin
            z = (ndx >= dy) ? ZONE3 : ZONE2;
        end else if (dx[ZW-1] && dy[ZW-1]) begin
            z = (ndx >= ndy) ? ZONE4 : ZONE5;
        end else begin
            z = (dx >= ndy) ? ZONE7 : ZONE6;
        end
        return z;
    endfunction

    function automatic point_t into_zone0(input zone_t z, input point_t p);
        point_t r;
        unique case (z)
            ZONE0: begin r.x = p.x;  r.y = p.y;  end
            ZONE1: begin r.x = p.y;  r.y = p.x;  end
            ZONE2: begin r.x = p.y;  r.y = -p.x; end
            ZONE3: begin r.x = -p.x; r.y = p.y;  end
            ZONE4: begin r.x = -p.x; r.y = -p.y; end
            ZONE5: begin r.x = -p.y; r.y = -p.x; end
            ZONE6: begin r.x = -p.y; r.y = p.x;  end
            ZONE7: begin r.x = p.x;  r.y = -p.y; end
        endcase
        return r;
    endfunction

    function automatic point_t from_zone0(input zone_t z, input point_t p);
        point_t r;
        unique case (z)
            ZONE0: begin r.x = p.x;  r.y = p.y;  end
            ZONE1: begin r.x = p.y;  r.y = p.x;  end
            ZONE2: begin r.x = -p.y; r.y = p.x;  end
            ZONE3: begin r.x = -p.x; r.y = p.y;  end
            ZONE4: begin r.x = -p.x; r.y = -p.y; end
            ZONE5: begin r.x = -p.y; r.y = -p.x; end
            ZONE6: begin r.x = p.y;  r.y = -p.x; end
            ZONE7: begin r.x = p.x;  r.y = -p.y; end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/midpoint_line_rasterizer.sv @@
// Midpoint line rasterizer, all eight octants. A begin beat (tuser low) carries two
// signed endpoints and a colour code; it produces no output and replaces any line in
// progress. Each step beat (tuser high) yields one pixel, first endpoint to second
// endpoint inclusive, with tlast on the final one; a step with no line open is
// dropped. Beats are accepted one per clock unless stage 1 is held by a full queue: a
// registered front end folds the line into the first octant and sets up the decision
// term, a four-entry queue follows, and the walker emits one pixel per clock while
// m_tready allows it, from a single add-and-compare on the decision term. A step beat
// passes the stage-1 register and the queue before its pixel is registered at the
// output; the queue absorbs up to four beats while m_tready is low.
module midpoint_line_rasterizer import mrl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, color_code, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // last_pixel
    output logic                  m_tlast
);

    logic   push, queue_full, pop, head_valid;
    entry_t push_entry, head;

    mrl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    mrl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mrl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ rtl/core/mrl_front.sv @@
module mrl_front import mrl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_x, start_y, end_x, end_y, color_code, zero pad
    input  logic [IN_DATA_W-1:0] s_tdata,
    // operation
    input  logic                 s_tuser,
    output logic                 push,
    output entry_t               push_entry,
    input  logic                 queue_full
);

    logic signed [COORD_BITS-1:0] in_x0, in_y0, in_x1, in_y1;
    logic                         load;

    logic                 s1_valid_reg, s1_valid_next;
    op_t                  s1_op_reg;
    point_t               s1_p0_reg, s1_p1_reg, s1_d_reg;
    logic [1:0]           s1_color_reg;

    point_t               z_p0, z_p1, z_d;
    zone_t                zone;
    logic signed [DW-1:0] east, diff;

    assign in_x0 = s_tdata[COORD_BITS-1:0];
    assign in_y0 = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_x1 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_y1 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign push     = s1_valid_reg && !queue_full;
    assign s_tready = !s1_valid_reg || !queue_full;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1: widen endpoints, take deltas
    always_ff @(posedge aclk) begin
        if (load) begin
            s1_op_reg    <= op_t'(s_tuser);
            s1_p0_reg.x  <= ZW'(in_x0);
            s1_p0_reg.y  <= ZW'(in_y0);
            s1_p1_reg.x  <= ZW'(in_x1);
            s1_p1_reg.y  <= ZW'(in_y1);
            s1_d_reg.x   <= ZW'(in_x1) - ZW'(in_x0);
            s1_d_reg.y   <= ZW'(in_y1) - ZW'(in_y0);
            s1_color_reg <= s_tdata[4*COORD_BITS+1:4*COORD_BITS];
        end
    end

    // stage 2: zone, fold into zone 0, decision set-up
    always_comb begin
        zone = pick_zone(s1_d_reg.x, s1_d_reg.y);
        z_p0 = into_zone0(zone, s1_p0_reg);
        z_p1 = into_zone0(zone, s1_p1_reg);
        z_d  = into_zone0(zone, s1_d_reg);
        east = DW'(z_d.y) + DW'(z_d.y);
        diff = DW'(z_d.y) - DW'(z_d.x);

        push_entry.op       = s1_op_reg;
        push_entry.zone     = zone;
        push_entry.start_x  = z_p0.x;
        push_entry.start_y  = z_p0.y;
        push_entry.stop_x   = z_p1.x;
        push_entry.decision = east - DW'(z_d.x);
        push_entry.east_inc = east;
        push_entry.diag_inc = diff + diff;
        push_entry.color    = s1_color_reg;
    end

endmodule

@@ rtl/core/mrl_queue.sv @@
module mrl_queue import mrl_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head
);

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/mrl_back.sv @@
module mrl_back import mrl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  entry_t                head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // last_pixel
    output logic                  m_tlast
);

    logic                 active_reg, active_next;
    zone_t                zone_reg, zone_next;
    logic signed [ZW-1:0] walk_x_reg, walk_x_next;
    logic signed [ZW-1:0] walk_y_reg, walk_y_next;
    logic signed [ZW-1:0] stop_x_reg, stop_x_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [DW-1:0] east_reg, east_next;
    logic signed [DW-1:0] diag_reg, diag_next;
    logic [1:0]           color_reg, color_next;

    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic [1:0]            m_color_reg;
    logic                  m_last_reg;

    logic   is_begin, emit, last;
    point_t walk_pt, pix;

    assign is_begin = (head.op == OP_BEGIN);
    assign pop      = head_valid && (is_begin || !active_reg || !m_valid_reg || m_tready);
    assign emit     = pop && !is_begin && active_reg;
    assign last     = (walk_x_reg >= stop_x_reg);

    assign walk_pt.x = walk_x_reg;
    assign walk_pt.y = walk_y_reg;
    assign pix       = from_zone0(zone_reg, walk_pt);

    always_comb begin
        active_next   = active_reg;
        zone_next     = zone_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        stop_x_next   = stop_x_reg;
        decision_next = decision_reg;
        east_next     = east_reg;
        diag_next     = diag_reg;
        color_next    = color_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;

        if (pop && is_begin) begin
            active_next   = 1'b1;
            zone_next     = head.zone;
            walk_x_next   = head.start_x;
            walk_y_next   = head.start_y;
            stop_x_next   = head.stop_x;
            decision_next = head.decision;
            east_next     = head.east_inc;
            diag_next     = head.diag_inc;
            color_next    = head.color;
        end else if (emit) begin
            m_valid_next = 1'b1;
            if (last) begin
                active_next = 1'b0;
            end else begin
                walk_x_next = walk_x_reg + 1'b1;
                if (decision_reg[DW-1]) begin
                    decision_next = decision_reg + east_reg;
                end else begin
                    walk_y_next   = walk_y_reg + 1'b1;
                    decision_next = decision_reg + diag_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zone_reg     <= zone_next;
        walk_x_reg   <= walk_x_next;
        walk_y_reg   <= walk_y_next;
        stop_x_reg   <= stop_x_next;
        decision_reg <= decision_next;
        east_reg     <= east_next;
        diag_reg     <= diag_next;
        color_reg    <= color_next;
        if (emit) begin
            m_x_reg     <= pix.x[COORD_BITS-1:0];
            m_y_reg     <= pix.y[COORD_BITS-1:0];
            m_color_reg <= color_reg;
            m_last_reg  <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_DATA_W'({m_color_reg, m_y_reg, m_x_reg});

endmodule
